FILE: design/newr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newr_pkg
// shared types and constants of the nearest entry within radius unit
// ----------------------------------------------------------------------------
package newr_pkg;

	localparam int COORD_W = 16;
	localparam int SLOT_W  = 5;
	localparam int DIST_W  = 16;
	localparam int SQ_W    = 32;
	localparam int SUM_W   = 34;

	localparam logic [DIST_W-1:0] RADIUS_RESET = 16'd2000;

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic                      func;
		logic [SLOT_W-1:0]         slot;
		logic                      present;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_RD,
		ST_DIF,
		ST_MUL,
		ST_ADD,
		ST_CMP,
		ST_SQRT,
		ST_DONE
	} state_t;

endpackage

FILE: design/newr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newr_in_if
// input item channel: write or query
// ----------------------------------------------------------------------------
interface newr_in_if;
	logic                               valid;
	logic                               ready;
	logic                               func;
	logic [newr_pkg::SLOT_W-1:0]         slot;
	logic                               present;
	logic signed [newr_pkg::COORD_W-1:0] coord_x;
	logic signed [newr_pkg::COORD_W-1:0] coord_y;
	logic signed [newr_pkg::COORD_W-1:0] coord_z;

	modport source (output valid, func, slot, present, coord_x, coord_y, coord_z,
		input ready);
	modport sink (input valid, func, slot, present, coord_x, coord_y, coord_z,
		output ready);
endinterface

FILE: design/newr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newr_out_if
// result item channel
// ----------------------------------------------------------------------------
interface newr_out_if;
	logic                        valid;
	logic                        ready;
	logic                        found;
	logic [newr_pkg::SLOT_W-1:0] best_slot;
	logic [newr_pkg::DIST_W-1:0] best_distance;

	modport source (output valid, found, best_slot, best_distance, input ready);
	modport sink (input valid, found, best_slot, best_distance, output ready);
endinterface

FILE: design/newr_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newr_cfg_if
// radius register write channel
// ----------------------------------------------------------------------------
interface newr_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [newr_pkg::DIST_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

FILE: design/newr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newr_front
// accepts items into a two-entry queue toward the scan engine
// ----------------------------------------------------------------------------
module newr_front (
	input  logic             clk,
	input  logic             arst_n,
	newr_in_if.sink          din,
	output logic             q_valid,
	output newr_pkg::item_t  q_item,
	input  logic             q_pop
);

	newr_pkg::item_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign din.ready = (count_q != 2'd2);
	assign push      = din.valid && din.ready;
	assign q_valid   = (count_q != 2'd0);
	assign pop       = q_pop && q_valid;
	assign q_item    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{func: din.func, slot: din.slot, present: din.present,
				coord_x: din.coord_x, coord_y: din.coord_y, coord_z: din.coord_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: design/newr_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newr_isqrt
// floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module newr_isqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [newr_pkg::SUM_W-1:0]  radicand,
	output logic                        done,
	output logic [newr_pkg::DIST_W-1:0] root
);

	localparam int STEPS = newr_pkg::SUM_W / 2;
	localparam int RW    = STEPS;
	localparam int REM_W = STEPS + 3;

	logic [newr_pkg::SUM_W-1:0] n_q;
	logic [REM_W-1:0]           rem_q;
	logic [RW-1:0]              root_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [REM_W-1:0]           rem_sh;
	logic [REM_W-1:0]           trial;

	assign rem_sh = {rem_q[REM_W-3:0], n_q[newr_pkg::SUM_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign done   = done_q;
	// radicand is always below a 16-bit square here
	assign root   = root_q[newr_pkg::DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[newr_pkg::SUM_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

endmodule

FILE: design/newr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newr_back
// point store, slot scan with distance test, result register
// ----------------------------------------------------------------------------
module newr_back #(
	parameter int TABLE_SLOTS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  newr_pkg::item_t             q_item,
	output logic                        q_pop,
	input  logic [newr_pkg::DIST_W-1:0] radius,
	newr_out_if.source                  dout
);

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(TABLE_SLOTS - 1);

	newr_pkg::state_t state_q, state_d;

	newr_pkg::point_t store [TABLE_SLOTS];
	logic [TABLE_SLOTS-1:0] present_q;

	newr_pkg::point_t rd_q;
	logic             pres_q;
	newr_pkg::point_t ref_q;
	logic [IW-1:0]    idx_q;
	logic             end_q;
	logic [newr_pkg::DIST_W-1:0] b_q;
	logic [newr_pkg::SQ_W-1:0]   bsq_q;
	logic             hit_q;
	logic [IW-1:0]    bidx_q;
	logic [newr_pkg::DIST_W-1:0] ax_s1, ay_s1, az_s1;
	logic [newr_pkg::SQ_W-1:0]   sx_s2, sy_s2, sz_s2;
	logic [newr_pkg::SUM_W-1:0]  sum_s3;

	logic out_valid_q;
	logic found_q;
	logic [newr_pkg::SLOT_W-1:0] slot_q;
	logic [newr_pkg::DIST_W-1:0] dist_q;

	logic is_write, wr_ok, better, sqrt_start, sqrt_done, out_load;
	logic [newr_pkg::DIST_W-1:0] sqrt_root;
	logic signed [newr_pkg::COORD_W:0] dx, dy, dz;

	assign is_write = (q_item.func == newr_pkg::FUNC_WRITE);
	assign wr_ok    = (32'(q_item.slot) < 32'(TABLE_SLOTS));
	assign better   = pres_q && (sum_s3 < newr_pkg::SUM_W'(bsq_q));
	assign dx = 17'(rd_q.x) - 17'(ref_q.x);
	assign dy = 17'(rd_q.y) - 17'(ref_q.y);
	assign dz = 17'(rd_q.z) - 17'(ref_q.z);

	newr_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (sum_s3),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			newr_pkg::ST_IDLE: if (q_valid) state_d = is_write ? newr_pkg::ST_DONE : newr_pkg::ST_SQ;
			newr_pkg::ST_SQ:   state_d = end_q ? newr_pkg::ST_DONE : newr_pkg::ST_RD;
			newr_pkg::ST_RD:   state_d = newr_pkg::ST_DIF;
			newr_pkg::ST_DIF:  state_d = newr_pkg::ST_MUL;
			newr_pkg::ST_MUL:  state_d = newr_pkg::ST_ADD;
			newr_pkg::ST_ADD:  state_d = newr_pkg::ST_CMP;
			newr_pkg::ST_CMP: begin
				if (better) state_d = newr_pkg::ST_SQRT;
				else if (idx_q == LAST) state_d = newr_pkg::ST_DONE;
				else state_d = newr_pkg::ST_RD;
			end
			newr_pkg::ST_SQRT: if (sqrt_done) state_d = newr_pkg::ST_SQ;
			newr_pkg::ST_DONE: if (out_load) state_d = newr_pkg::ST_IDLE;
			default:           state_d = newr_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		q_pop      = (state_q == newr_pkg::ST_IDLE) && q_valid;
		sqrt_start = (state_q == newr_pkg::ST_CMP) && better;
		out_load   = (state_q == newr_pkg::ST_DONE) && (!out_valid_q || dout.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= newr_pkg::ST_IDLE;
			present_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop && is_write && wr_ok) present_q[IW'(q_item.slot)] <= q_item.present;
			if (out_load) out_valid_q <= 1'b1;
			else if (dout.ready) out_valid_q <= 1'b0;
		end
	end

	// point memory, registered read
	always_ff @(posedge clk) begin
		if (q_pop && is_write && wr_ok) begin
			store[IW'(q_item.slot)] <= '{x: q_item.coord_x, y: q_item.coord_y,
				z: q_item.coord_z};
		end
		rd_q   <= store[idx_q];
		pres_q <= present_q[idx_q];
	end

	always_ff @(posedge clk) begin
		ax_s1  <= newr_pkg::DIST_W'(dx[newr_pkg::COORD_W] ? -dx : dx);
		ay_s1  <= newr_pkg::DIST_W'(dy[newr_pkg::COORD_W] ? -dy : dy);
		az_s1  <= newr_pkg::DIST_W'(dz[newr_pkg::COORD_W] ? -dz : dz);
		sx_s2  <= ax_s1 * ax_s1;
		sy_s2  <= ay_s1 * ay_s1;
		sz_s2  <= az_s1 * az_s1;
		sum_s3 <= newr_pkg::SUM_W'(sx_s2) + newr_pkg::SUM_W'(sy_s2)
			+ newr_pkg::SUM_W'(sz_s2);

		unique case (state_q)
			newr_pkg::ST_IDLE: begin
				hit_q  <= 1'b0;
				bidx_q <= '0;
				idx_q  <= '0;
				end_q  <= 1'b0;
				b_q    <= radius;
				ref_q  <= '{x: q_item.coord_x, y: q_item.coord_y, z: q_item.coord_z};
			end
			newr_pkg::ST_SQ: bsq_q <= b_q * b_q;
			newr_pkg::ST_CMP: begin
				end_q <= (idx_q == LAST);
				if (!better && idx_q != LAST) idx_q <= idx_q + IW'(1);
			end
			newr_pkg::ST_SQRT: begin
				if (sqrt_done) begin
					b_q    <= sqrt_root;
					bidx_q <= idx_q;
					hit_q  <= 1'b1;
					if (!end_q) idx_q <= idx_q + IW'(1);
				end
			end
			default: ;
		endcase

		if (out_load) begin
			found_q <= hit_q;
			slot_q  <= hit_q ? newr_pkg::SLOT_W'(bidx_q) : '0;
			dist_q  <= hit_q ? b_q : '0;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.found         = found_q;
	assign dout.best_slot     = slot_q;
	assign dout.best_distance = dist_q;

endmodule

FILE: design/nearest_entry_within_radius_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_entry_within_radius_unit
// nearest stored 3-d point to a query point, within a search radius
// ----------------------------------------------------------------------------
// A write item stores a point and its present flag in one slot; a query item
// scans all slots in index order and returns the last slot whose floor root
// distance is strictly below the best so far, the best starting at the radius
// register (reset 2000), so the nearest slot wins and a tie goes to the lower
// index. Every item yields exactly one result item; writes and misses return
// all zeros. Items enter a two-entry queue, so until it is full the input
// keeps accepting while the scan engine works and while a result waits at
// the output. A query loops over the slots (memory read, difference,
// squares, sum, compare), and each slot that improves the best adds the
// bit-serial square root and the squaring of the new bound. The point
// store has no reset; present flags clear at reset. The radius may be written
// at any cycle the block is idle.
// ----------------------------------------------------------------------------
module nearest_entry_within_radius_unit #(
	parameter int TABLE_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	newr_in_if.sink     din,
	newr_out_if.source  dout,
	newr_cfg_if.sink    cfg
);

	logic                        q_valid;
	newr_pkg::item_t             q_item;
	logic                        q_pop;
	logic [newr_pkg::DIST_W-1:0] radius_q;

	// radius register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= newr_pkg::RADIUS_RESET;
		end else if (cfg.valid) begin
			radius_q <= cfg.data;
		end
	end

	// front: accept and queue items
	newr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.din     (din),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	// back: store, scan and result register
	newr_back #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.radius  (radius_q),
		.dout    (dout)
	);

endmodule

FILE: tb/nearest_entry_within_radius_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_entry_within_radius_unit_tb
// self-checking bench for the nearest entry within radius unit
// ----------------------------------------------------------------------------
// A directed table of writes and queries comes first, with the result typed in
// where it is obvious; then random phases of clustered points and queries run
// under several radius settings. Every result is checked against a behavioral
// model of the slot table, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module nearest_entry_within_radius_unit_tb;

	localparam int NSLOTS    = 32;
	localparam int CYC_LIMIT = 2000000;

	logic clk;
	logic arst_n;

	newr_in_if  din ();
	newr_out_if dout ();
	newr_cfg_if cfg ();

	nearest_entry_within_radius_unit #(.TABLE_SLOTS(NSLOTS)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.dout   (dout),
		.cfg    (cfg)
	);

	typedef struct packed {
		logic                        found;
		logic [newr_pkg::SLOT_W-1:0] best_slot;
		logic [newr_pkg::DIST_W-1:0] best_distance;
	} answer_t;

	// directed row: item plus optional typed-in result
	typedef struct {
		newr_pkg::item_t it;
		bit              typed;
		answer_t         want;
	} row_t;

	// model copy of the table and radius
	newr_pkg::point_t            mdl_pt [NSLOTS];
	bit                          mdl_pres [NSLOTS];
	logic [newr_pkg::DIST_W-1:0] mdl_radius;

	answer_t pending_answers [$];
	answer_t typed_answers [$];
	bit      typed_flags [$];

	int errors;
	int cycles;
	int n_items;
	int n_queries;
	int n_hits;
	int n_results;
	int n_radius;

	// floor square root of a wide sum, bit by bit
	function automatic longint unsigned floor_root(longint unsigned n);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// apply one item to the model table and return the answer it causes
	function automatic answer_t search_table(newr_pkg::item_t it);
		answer_t a;
		longint signed dx, dy, dz;
		longint unsigned best, d;
		a = '0;
		best = mdl_radius;
		if (it.func == newr_pkg::FUNC_WRITE) begin
			mdl_pt[it.slot] = '{x: it.coord_x, y: it.coord_y, z: it.coord_z};
			mdl_pres[it.slot] = it.present;
		end else begin
			for (int i = 0; i < NSLOTS; i++) begin
				if (mdl_pres[i]) begin
					dx = longint'(mdl_pt[i].x) - longint'(it.coord_x);
					dy = longint'(mdl_pt[i].y) - longint'(it.coord_y);
					dz = longint'(mdl_pt[i].z) - longint'(it.coord_z);
					d = floor_root(dx * dx + dy * dy + dz * dz);
					if (d < best) begin
						best = d;
						a.found = 1'b1;
						a.best_slot = i[newr_pkg::SLOT_W-1:0];
						a.best_distance = d[newr_pkg::DIST_W-1:0];
					end
				end
			end
		end
		return a;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cycle counter and watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYC_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("** nearest_entry_within_radius_unit: FAILED **");
				$finish;
			end
		end
	end

	// receiver: stalls on its own pattern, with quiet stretches
	int stall_mode;
	initial begin
		dout.ready <= 1'b0;
		stall_mode = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: dout.ready <= 1'b1;
				1: dout.ready <= ($urandom_range(0, 3) != 0);
				default: dout.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// result checker, sampled at the edge where the handshake completes
	answer_t got, want;
	bit      is_typed;
	answer_t typed_want;
	always @(posedge clk) begin
		if (arst_n && dout.valid && dout.ready) begin
			n_results++;
			if (pending_answers.size() == 0) begin
				errors++;
				$display("unexpected result item at cycle %0d", cycles);
			end else begin
				want = pending_answers.pop_front();
				is_typed = typed_flags.pop_front();
				typed_want = typed_answers.pop_front();
				got = '{found: dout.found, best_slot: dout.best_slot,
					best_distance: dout.best_distance};
				// typed-in values must agree with the model too
				if (is_typed && typed_want != want)
					report_mismatch("typed row vs model", typed_want, want);
				if (got.found != want.found)
					report_mismatch("found", got.found, want.found);
				if (got.best_slot != want.best_slot)
					report_mismatch("best_slot", got.best_slot, want.best_slot);
				if (got.best_distance != want.best_distance)
					report_mismatch("best_distance", got.best_distance,
						want.best_distance);
			end
		end
	end

	// send one item, holding valid until accepted; gaps come from the caller
	task automatic send_item(newr_pkg::item_t it, bit typed, answer_t tw);
		din.valid   <= 1'b1;
		din.func    <= it.func;
		din.slot    <= it.slot;
		din.present <= it.present;
		din.coord_x <= it.coord_x;
		din.coord_y <= it.coord_y;
		din.coord_z <= it.coord_z;
		do @(posedge clk); while (!din.ready);
		// predict at acceptance so queue order matches item order
		pending_answers.push_back(search_table(it));
		typed_flags.push_back(typed);
		typed_answers.push_back(tw);
		n_items++;
		if (it.func == newr_pkg::FUNC_QUERY) begin
			n_queries++;
			if (pending_answers[$].found)
				n_hits++;
		end
	endtask

	// bursty sender: random gap before a new burst, valid held inside one
	int burst_left;
	task automatic pace_and_send(newr_pkg::item_t it, bit typed, answer_t tw);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap != 0) begin
				din.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		send_item(it, typed, tw);
		burst_left--;
	endtask

	// wait out every result, then the longest scan before touching the radius
	task automatic drain();
		din.valid <= 1'b0;
		burst_left = 0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (NSLOTS * 30) @(posedge clk);
	endtask

	task automatic write_radius(logic [newr_pkg::DIST_W-1:0] r);
		cfg.valid <= 1'b1;
		cfg.data  <= r;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		mdl_radius = r;
		n_radius++;
	endtask

	function automatic newr_pkg::item_t make_item(logic f, int s, logic p, int x, int y,
		int z);
		newr_pkg::item_t it;
		it.func = f;
		it.slot = s[newr_pkg::SLOT_W-1:0];
		it.present = p;
		it.coord_x = x[newr_pkg::COORD_W-1:0];
		it.coord_y = y[newr_pkg::COORD_W-1:0];
		it.coord_z = z[newr_pkg::COORD_W-1:0];
		return it;
	endfunction

	function automatic logic signed [newr_pkg::COORD_W-1:0] near_coord(int c, int spread);
		int v;
		v = c + $urandom_range(0, 2 * spread) - spread;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[newr_pkg::COORD_W-1:0];
	endfunction

	row_t            rows [$];
	answer_t         zero_ans;
	newr_pkg::item_t it;
	int              kind;
	int              cx, cy, cz, spread;
	logic [newr_pkg::DIST_W-1:0] radii [6] = '{16'd0, 16'd1, 16'd2000, 16'd65535, 16'd300,
		16'd40000};

	initial begin
		errors = 0; n_items = 0; n_queries = 0; n_hits = 0; n_results = 0;
		n_radius = 0; burst_left = 0;
		zero_ans = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			mdl_pt[i] = '0;
			mdl_pres[i] = 1'b0;
		end
		mdl_radius = newr_pkg::RADIUS_RESET;
		din.valid <= 1'b0; din.func <= newr_pkg::FUNC_WRITE; din.slot <= '0;
		din.present <= 1'b0;
		din.coord_x <= '0; din.coord_y <= '0; din.coord_z <= '0;
		cfg.valid <= 1'b0; cfg.data <= '0;

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; typed answers only where obvious
		// query on an empty table after reset: nothing found
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 7, 1, 0, 0, 0), 1, zero_ans});
		// writes always return all zeros
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 0, 1, 100, 0, 0), 1, zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 31, 1, -32768, -32768, -32768), 1,
			zero_ans});
		// exact hit at slot 0
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, 100, 0, 0), 1,
			'{1'b1, 5'd0, 16'd0}});
		// far corner: opposite extreme exceeds the radius
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, 32767, 32767, 32767), 1,
			zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, -32768, -32768, -32768), 1,
			'{1'b1, 5'd31, 16'd0}});
		// tie: slot 1 at the same distance as slot 0 loses to the lower index
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 1, 1, 100, 0, 0), 1, zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, 103, 4, 0), 1,
			'{1'b1, 5'd0, 16'd5}});
		// later, closer slot wins
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 2, 1, 104, 4, 0), 1, zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, 103, 4, 0), 0, zero_ans});
		// clear slot 0 and 1, query again
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 0, 0, 0, 0, 0), 1, zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 1, 0, 0, 0, 0), 1, zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 31, 1, 100, 0, 0), 0, zero_ans});
		// distance right at and below the radius bound
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 2, 1, 0, 0, 0), 1, zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, 2000, 0, 0), 0, zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, 1999, 0, 0), 0, zero_ans});
		// floor root of a non-square sum
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 0, 3, 3, 3), 0, zero_ans});
		// mixed signs, large components
		rows.push_back('{make_item(newr_pkg::FUNC_WRITE, 16, 1, 32767, -32768, 1234), 1,
			zero_ans});
		rows.push_back('{make_item(newr_pkg::FUNC_QUERY, 0, 1, 32000, -32000, 1500), 0,
			zero_ans});
		foreach (rows[i])
			pace_and_send(rows[i].it, rows[i].typed, rows[i].want);
		drain();

		// random phases, one radius each, extremes included
		for (int ph = 0; ph < 11; ph++) begin
			if (ph < 6)
				write_radius(radii[ph]);
			else
				write_radius($urandom_range(0, 65535));
			cx = $urandom_range(0, 65535) - 32768;
			cy = $urandom_range(0, 65535) - 32768;
			cz = $urandom_range(0, 65535) - 32768;
			spread = (ph % 3 == 0) ? 32767 : $urandom_range(2, 3000);
			for (int k = 0; k < 48; k++) begin
				kind = $urandom_range(0, 9);
				if (kind < 4) begin
					// clustered write, mostly present
					it = make_item(newr_pkg::FUNC_WRITE, $urandom_range(0, NSLOTS - 1),
						$urandom_range(0, 4) != 0, 0, 0, 0);
					it.coord_x = near_coord(cx, spread);
					it.coord_y = near_coord(cy, spread);
					it.coord_z = near_coord(cz, spread);
				end else if (kind < 9) begin
					// query near the cluster; slot and present are noise
					it = make_item(newr_pkg::FUNC_QUERY, $urandom_range(0, NSLOTS - 1),
						$urandom_range(0, 1), 0, 0, 0);
					it.coord_x = near_coord(cx, spread);
					it.coord_y = near_coord(cy, spread);
					it.coord_z = near_coord(cz, spread);
				end else begin
					// fully random item
					it = newr_pkg::item_t'({$urandom, $urandom});
				end
				pace_and_send(it, 0, zero_ans);
			end
			drain();
		end

		$display("run covered %0d items, %0d queries (%0d hits), %0d results",
			n_items, n_queries, n_hits, n_results);
		$display("radius written %0d times, including 0, 1 and 65535", n_radius);
		if (errors == 0 && pending_answers.size() == 0) begin
			$display("** nearest_entry_within_radius_unit: PASSED **");
		end else begin
			$display("%0d mismatches, %0d results outstanding", errors,
				pending_answers.size());
			$display("** nearest_entry_within_radius_unit: FAILED **");
		end
		$finish;
	end

endmodule
